// ----- hdl/sitda_pkg.sv -----
// ----------------------------------------------------------------------------
// sitda_pkg
// Shared types and character codes for the signed integer to decimal text unit.
// ----------------------------------------------------------------------------
package sitda_pkg;

  localparam int CHAR_W = 6;

  localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 6'd57;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_SIGN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic skip;
    logic put_sign;
    logic put_digit;
  } ctrl_t;

endpackage

// ----- hdl/signed_int_to_decimal_ascii_unit.sv -----
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_unit
// Converts a signed integer to decimal ASCII text, one character per word.
// Sequence: takes the word, runs a bit-serial shift-add-3 over the magnitude,
// one magnitude bit a cycle in the single double-dabble register, drops leading
// zeros down to the first digit, then one character per cycle while the output
// is not stalled, a minus first for a negative value. A new value is taken only
// once the last character of the previous one has been issued.
// Reset: synchronous, clears the sequencer and the output valid.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_unit #(
  parameter int WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           item_valid,
  output logic                           item_ready,
  input  logic signed [WIDTH-1:0]        value,
  output logic                           text_valid,
  input  logic                           text_ready,
  output logic [sitda_pkg::CHAR_W-1:0]   character,
  output logic                           last
);

  localparam int NDIG  = (WIDTH * 1233) / 4096 + 1;
  localparam int BCD_W = NDIG * 4;
  localparam int CNT_W = $clog2(WIDTH);
  localparam int REM_W = $clog2(NDIG + 1);

  sitda_pkg::state_t state, state_next;
  sitda_pkg::ctrl_t  ctrl;

  logic [WIDTH-1:0] mag;
  logic [BCD_W-1:0] bcd;
  logic [BCD_W-1:0] bcd_adj;
  logic             neg;
  logic [CNT_W-1:0] cnt;
  logic [REM_W-1:0] rem;
  logic [3:0]       top;
  logic             slot_free;
  logic             top_zero;
  logic             rem_one;

  assign top       = bcd[BCD_W-1 -: 4];
  assign slot_free = !text_valid || text_ready;
  assign top_zero  = (top == 4'd0);
  assign rem_one   = (rem == REM_W'(1));

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      bcd_adj[i*4 +: 4] = (bcd[i*4 +: 4] >= 4'd5) ? bcd[i*4 +: 4] + 4'd3 : bcd[i*4 +: 4];
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      sitda_pkg::ST_IDLE: begin
        if (item_valid) state_next = sitda_pkg::ST_CONV;
      end
      sitda_pkg::ST_CONV: begin
        if (cnt == CNT_W'(WIDTH - 1)) state_next = sitda_pkg::ST_SKIP;
      end
      sitda_pkg::ST_SKIP: begin
        if (!(top_zero && !rem_one)) begin
          state_next = neg ? sitda_pkg::ST_SIGN : sitda_pkg::ST_EMIT;
        end
      end
      sitda_pkg::ST_SIGN: begin
        if (slot_free) state_next = sitda_pkg::ST_EMIT;
      end
      sitda_pkg::ST_EMIT: begin
        if (slot_free && rem_one) state_next = sitda_pkg::ST_IDLE;
      end
      default: state_next = sitda_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl       = '0;
    item_ready = 1'b0;
    case (state)
      sitda_pkg::ST_IDLE: begin
        item_ready = 1'b1;
        ctrl.load  = item_valid;
      end
      sitda_pkg::ST_CONV: ctrl.step      = 1'b1;
      sitda_pkg::ST_SKIP: ctrl.skip      = top_zero && !rem_one;
      sitda_pkg::ST_SIGN: ctrl.put_sign  = slot_free;
      sitda_pkg::ST_EMIT: ctrl.put_digit = slot_free;
      default: ctrl = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= sitda_pkg::ST_IDLE;
      text_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctrl.put_sign || ctrl.put_digit) begin
        text_valid <= 1'b1;
      end else if (text_ready) begin
        text_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      neg <= value[WIDTH-1];
      mag <= value[WIDTH-1] ? (~value + WIDTH'(1)) : value;
      bcd <= '0;
      cnt <= '0;
      rem <= REM_W'(NDIG);
    end
    if (ctrl.step) begin
      bcd <= {bcd_adj[BCD_W-2:0], mag[WIDTH-1]};
      mag <= {mag[WIDTH-2:0], 1'b0};
      cnt <= cnt + CNT_W'(1);
    end
    if (ctrl.skip || ctrl.put_digit) begin
      bcd <= {bcd[BCD_W-5:0], 4'd0};
      rem <= rem - REM_W'(1);
    end
    if (ctrl.put_sign) begin
      character <= sitda_pkg::CHAR_MINUS;
      last      <= 1'b0;
    end
    if (ctrl.put_digit) begin
      character <= sitda_pkg::CHAR_ZERO + {2'b00, top};
      last      <= rem_one;
    end
  end

endmodule

// ----- hdl/sitda_checker.sv -----
// ----------------------------------------------------------------------------
// sitda_checker
// Port-level checks on the text word stream of the decimal text unit.
// ----------------------------------------------------------------------------
module sitda_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         text_valid,
  input logic                         text_ready,
  input logic [sitda_pkg::CHAR_W-1:0] character,
  input logic                         last
);

  // stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    text_valid && !text_ready |=> text_valid && $stable(character) && $stable(last))
    else $error("stalled text word changed");

  // only a minus or a digit
  a_code: assert property (@(posedge clk) disable iff (rst)
    text_valid |-> (character == sitda_pkg::CHAR_MINUS) ||
                   ((character >= sitda_pkg::CHAR_ZERO) && (character <= sitda_pkg::CHAR_NINE)))
    else $error("text word is not a minus or a digit");

  // a sign is never the final character
  a_sign: assert property (@(posedge clk) disable iff (rst)
    text_valid && (character == sitda_pkg::CHAR_MINUS) |-> !last)
    else $error("minus marked last");

  // a taken sign is followed by a digit, never another sign
  a_after_sign: assert property (@(posedge clk) disable iff (rst)
    text_valid && text_ready && (character == sitda_pkg::CHAR_MINUS) ##1 text_valid
    |-> character != sitda_pkg::CHAR_MINUS)
    else $error("minus followed by minus");

  a_reset: assert property (@(posedge clk) rst |=> !text_valid)
    else $error("text valid after reset");

endmodule

bind signed_int_to_decimal_ascii_unit sitda_checker u_sitda_checker (
  .clk        (clk),
  .rst        (rst),
  .text_valid (text_valid),
  .text_ready (text_ready),
  .character  (character),
  .last       (last)
);
